// ===== rtl/core/control_packet_decoder_core_assert.svh =====
// Assertion macros shared by the control packet decoder modules.
`ifndef CONTROL_PACKET_DECODER_CORE_ASSERT_SVH
`define CONTROL_PACKET_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define CPD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define CPD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CPD_ASSERT_IMP(lbl, ante, cons, msg)
`define CPD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/cpd_pkg.sv =====
// Types, constants and helper functions of the control packet decoder.
`default_nettype none

package cpd_pkg;

    localparam int PACKET_BYTES = 30;
    localparam int HDR_BYTES    = 16;
    localparam int CRC_BYTES    = 2;
    localparam int BYTE_IDX_W   = $clog2(PACKET_BYTES);
    localparam int COUNT_W      = 6;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;
    localparam logic [7:0] PAYLOAD_LEN = 8'(PACKET_BYTES - HDR_BYTES - CRC_BYTES);
    localparam int CRC_AT       = PACKET_BYTES - CRC_BYTES;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] STICK_MAX = 16'd1000;
    localparam logic signed [15:0] STICK_MIN = -16'sd1000;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TDATA_W    = 152;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAGIC   = 2'd0,
        REG_VERSION = 2'd1,
        REG_TYPE    = 2'd2,
        REG_FLAGS   = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_SIZE     = 4'd1,
        ST_MAGIC    = 4'd2,
        ST_VERSION  = 4'd3,
        ST_TYPE     = 4'd4,
        ST_LENGTH   = 4'd5,
        ST_RESERVED = 4'd6,
        ST_CRC      = 4'd7,
        ST_FLAGS    = 4'd8,
        ST_RANGE    = 4'd9
    } status_t;

    typedef logic [PACKET_BYTES-1:0][7:0] pkt_bytes_t;

    typedef struct packed {
        logic        size_ok;
        logic [15:0] crc;
        pkt_bytes_t  bytes;
    } pkt_entry_t;

    typedef struct packed {
        logic [15:0] magic_word;
        logic [7:0]  version_byte;
        logic [7:0]  packet_type_code;
        logic [15:0] allowed_flags;
    } cfg_t;

    typedef struct packed {
        logic [9:0]  aux_two;
        logic [9:0]  aux_one;
        logic [10:0] yaw;
        logic [10:0] pitch;
        logic [10:0] roll;
        logic [9:0]  throttle;
        logic [31:0] sender_time;
        logic [15:0] header_flags;
        logic [15:0] session;
        logic [15:0] sequence_res;
        status_t     status_code;
    } result_t;

    localparam int TDATA_PAD = TDATA_W - $bits(result_t);

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [15:0] get16(input pkt_bytes_t b, input logic [BYTE_IDX_W-1:0] at);
        logic [BYTE_IDX_W-1:0] hi;
        hi = at + 1'b1;
        return {b[hi], b[at]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cpd_front.sv =====
// Front end: byte intake, packet store, running CRC and packet snapshot.
`default_nettype none

module cpd_front import cpd_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,   // last_byte
    input  wire logic       q_full,
    output logic            push,
    output pkt_entry_t      push_entry
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [15:0]        crc_reg, crc_next;
    logic [7:0]         d1_reg, d2_reg;
    logic [7:0]         store_reg [PACKET_BYTES];
    logic               accept;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] crc_pos;
    logic [15:0]        crc_upd;
    pkt_bytes_t         snap;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && s_tlast;

    assign count_inc = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
    assign crc_pos   = count_reg - COUNT_W'(2);
    assign crc_upd   = ((count_reg >= COUNT_W'(2)) && (crc_pos < COUNT_W'(PACKET_BYTES)))
                       ? crc_byte(crc_reg, d2_reg) : crc_reg;

    always_comb begin
        for (int i = 0; i < PACKET_BYTES; i++) begin
            snap[i] = (count_reg == COUNT_W'(i)) ? s_tdata : store_reg[i];
        end
        push_entry.size_ok = (count_inc == COUNT_W'(PACKET_BYTES));
        push_entry.crc     = crc_upd;
        push_entry.bytes   = snap;
    end

    always_comb begin
        count_next = count_reg;
        crc_next   = crc_reg;
        if (accept) begin
            if (s_tlast) begin
                count_next = '0;
                crc_next   = CRC_INIT;
            end else begin
                count_next = count_inc;
                crc_next   = crc_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
        end else begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            d1_reg <= s_tdata;
            d2_reg <= d1_reg;
            if (count_reg < COUNT_W'(PACKET_BYTES)) begin
                store_reg[count_reg[BYTE_IDX_W-1:0]] <= s_tdata;
            end
        end
    end

    `include "control_packet_decoder_core_assert.svh"

    `CPD_ASSERT_NXT(a_count_clear, push, count_reg == '0, "byte count not cleared after last beat")
    `CPD_ASSERT_NXT(a_count_step, accept && !s_tlast && (count_reg != COUNT_MAX),
        count_reg == COUNT_W'($past(count_reg) + 1'b1), "byte count did not advance")

endmodule

`default_nettype wire

// ===== rtl/core/cpd_queue.sv =====
// Short packet queue between the intake front end and the checking back end.
`default_nettype none

module cpd_queue import cpd_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire pkt_entry_t push_entry,
    input  wire logic       pop,
    output logic            full,
    output logic            head_valid,
    output pkt_entry_t      head_entry
);

    pkt_entry_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `include "control_packet_decoder_core_assert.svh"

    `CPD_ASSERT_IMP(a_no_push_full, full, !push, "packet pushed into a full queue")
    `CPD_ASSERT_IMP(a_no_pop_empty, pop, head_valid, "packet popped from an empty queue")

endmodule

`default_nettype wire

// ===== rtl/core/cpd_back.sv =====
// Back end: configuration registers, packet checks, field decode and output register.
`default_nettype none

module cpd_back import cpd_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  head_valid,
    input  wire pkt_entry_t            head_entry,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [TDATA_W-1:0]         m_tdata
);

    cfg_t       cfg_reg, cfg_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    result_t    res;
    status_t    status;
    pkt_bytes_t b;
    logic       range_bad;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_wr_index))
                REG_MAGIC:   cfg_next.magic_word       = cfg_wr_data;
                REG_VERSION: cfg_next.version_byte     = cfg_wr_data[7:0];
                REG_TYPE:    cfg_next.packet_type_code = cfg_wr_data[7:0];
                REG_FLAGS:   cfg_next.allowed_flags    = cfg_wr_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    assign b = head_entry.bytes;

    assign range_bad =
        (get16(b, BYTE_IDX_W'(16)) > STICK_MAX) ||
        ($signed(get16(b, BYTE_IDX_W'(18))) < STICK_MIN) ||
        ($signed(get16(b, BYTE_IDX_W'(18))) > $signed(STICK_MAX)) ||
        ($signed(get16(b, BYTE_IDX_W'(20))) < STICK_MIN) ||
        ($signed(get16(b, BYTE_IDX_W'(20))) > $signed(STICK_MAX)) ||
        ($signed(get16(b, BYTE_IDX_W'(22))) < STICK_MIN) ||
        ($signed(get16(b, BYTE_IDX_W'(22))) > $signed(STICK_MAX)) ||
        (get16(b, BYTE_IDX_W'(24)) > STICK_MAX) ||
        (get16(b, BYTE_IDX_W'(26)) > STICK_MAX);

    always_comb begin
        if (!head_entry.size_ok) begin
            status = ST_SIZE;
        end else if (get16(b, BYTE_IDX_W'(0)) != cfg_reg.magic_word) begin
            status = ST_MAGIC;
        end else if (b[2] != cfg_reg.version_byte) begin
            status = ST_VERSION;
        end else if (b[3] != cfg_reg.packet_type_code) begin
            status = ST_TYPE;
        end else if (b[10] != PAYLOAD_LEN) begin
            status = ST_LENGTH;
        end else if (b[11] != 8'd0) begin
            status = ST_RESERVED;
        end else if (get16(b, BYTE_IDX_W'(CRC_AT)) != head_entry.crc) begin
            status = ST_CRC;
        end else if ((get16(b, BYTE_IDX_W'(8)) & ~cfg_reg.allowed_flags) != 16'd0) begin
            status = ST_FLAGS;
        end else if (range_bad) begin
            status = ST_RANGE;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        res = '0;
        res.status_code = status;
        if (status == ST_OK) begin
            res.sequence_res = get16(b, BYTE_IDX_W'(4));
            res.session      = get16(b, BYTE_IDX_W'(6));
            res.header_flags = get16(b, BYTE_IDX_W'(8));
            res.sender_time  = {get16(b, BYTE_IDX_W'(14)), get16(b, BYTE_IDX_W'(12))};
            res.throttle     = 10'(get16(b, BYTE_IDX_W'(16)));
            res.roll         = 11'(get16(b, BYTE_IDX_W'(18)));
            res.pitch        = 11'(get16(b, BYTE_IDX_W'(20)));
            res.yaw          = 11'(get16(b, BYTE_IDX_W'(22)));
            res.aux_one      = 10'(get16(b, BYTE_IDX_W'(24)));
            res.aux_two      = 10'(get16(b, BYTE_IDX_W'(26)));
        end
    end

    assign pop = head_valid && (!out_valid_reg || m_tready);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{TDATA_PAD{1'b0}}, out_reg};

    `include "control_packet_decoder_core_assert.svh"

    `CPD_ASSERT_IMP(a_fail_zero, out_valid_reg && (out_reg.status_code != ST_OK),
        {out_reg.aux_two, out_reg.aux_one, out_reg.yaw, out_reg.pitch, out_reg.roll,
         out_reg.throttle, out_reg.sender_time, out_reg.header_flags, out_reg.session,
         out_reg.sequence_res} == '0, "decoded fields set on a failed packet")

endmodule

`default_nettype wire

// ===== rtl/core/control_packet_decoder_core.sv =====
// Top level of the control packet decoder: front end, packet queue and back end.
//
// Takes one packet byte per cycle on the s_ side while s_tready is high and presents one
// result beat on the m_ side once the beat marked by s_tlast has passed the queue write
// and then the output register. The front end updates its CRC-16 and packet store on
// each accepted byte; whole packets then pass through a two-entry queue to the checker,
// whose output register holds a result until it is taken. s_tready drops only while two
// finished packets wait behind a stalled output. The packet store has no reset; no
// clearing pass runs after reset.
`default_nettype none

module control_packet_decoder_core import cpd_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] data_byte
    input  wire logic                  s_tlast,   // last_byte
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [3:0] status_code, [19:4] sequence_res, [35:20] session, [51:36] header_flags,
    // [83:52] sender_time, [93:84] throttle, [104:94] roll, [115:105] pitch,
    // [126:116] yaw, [136:127] aux_one, [146:137] aux_two, [151:147] zero
    output logic [TDATA_W-1:0]         m_tdata
);

    logic       push;
    pkt_entry_t push_entry;
    logic       pop;
    logic       q_full;
    logic       head_valid;
    pkt_entry_t head_entry;

    cpd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    cpd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    cpd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

`default_nettype wire

// ===== verif/control_packet_decoder_core_tb.sv =====
// Self-checking testbench for the control packet decoder core: byte stream in, decoded packets out.
module control_packet_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cpd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_BYTES = 80;
    localparam int MIN_PACKETS  = 2;
    localparam int MAX_FRAME    = 70;

    typedef logic [15:0] word_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;

    // decoder shadow state
    logic [7:0]  shadow_bytes [PACKET_BYTES];
    logic [15:0] crc_run = CRC_INIT;
    logic [5:0]  bytes_seen = '0;
    cfg_t        regs_now = '0;
    result_t     decoded_due [$];
    result_t     want_result;
    result_t     seen_result;

    logic [7:0]  draft [PACKET_BYTES];
    int          errors = 0;
    int          cycles = 0;
    int          bytes_sent = 0;
    int          frames_sent = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    bit          hold_rx_req = 1'b0;
    bit          rx_holding = 1'b0;

    control_packet_decoder_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic word_t stored_word(int at);
        return {shadow_bytes[at + 1], shadow_bytes[at]};
    endfunction

    function automatic bit stick_bad(word_t w, bit is_signed);
        if (is_signed) begin
            return $signed(w) < -1000 || $signed(w) > 1000;
        end
        return w > 16'd1000;
    endfunction

    function automatic status_t packet_status(int length);
        if (length != PACKET_BYTES) return ST_SIZE;
        if (stored_word(0) != regs_now.magic_word) return ST_MAGIC;
        if (shadow_bytes[2] != regs_now.version_byte) return ST_VERSION;
        if (shadow_bytes[3] != regs_now.packet_type_code) return ST_TYPE;
        if (shadow_bytes[10] != PAYLOAD_LEN) return ST_LENGTH;
        if (shadow_bytes[11] != 8'd0) return ST_RESERVED;
        if (stored_word(CRC_AT) != crc_run) return ST_CRC;
        if ((stored_word(8) & ~regs_now.allowed_flags) != 16'd0) return ST_FLAGS;
        if (stick_bad(stored_word(16), 1'b0) || stick_bad(stored_word(18), 1'b1) ||
            stick_bad(stored_word(20), 1'b1) || stick_bad(stored_word(22), 1'b1) ||
            stick_bad(stored_word(24), 1'b0) || stick_bad(stored_word(26), 1'b0)) begin
            return ST_RANGE;
        end
        return ST_OK;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic last);
        int      pos;
        result_t r;
        pos = int'(bytes_seen);
        if (pos < PACKET_BYTES) shadow_bytes[pos] = b;
        // CRC trails arrival by two bytes so the trailer stays out of it
        if (pos >= 2 && pos - 2 < PACKET_BYTES) begin
            crc_run = crc16_step(crc_run, shadow_bytes[pos - 2]);
        end
        if (bytes_seen < COUNT_MAX) bytes_seen++;
        if (!last) return;
        r = '0;
        r.status_code = packet_status(int'(bytes_seen));
        if (r.status_code == ST_OK) begin
            r.sequence_res = stored_word(4);
            r.session      = stored_word(6);
            r.header_flags = stored_word(8);
            r.sender_time  = {stored_word(14), stored_word(12)};
            r.throttle     = 10'(stored_word(16));
            r.roll         = 11'(stored_word(18));
            r.pitch        = 11'(stored_word(20));
            r.yaw          = 11'(stored_word(22));
            r.aux_one      = 10'(stored_word(24));
            r.aux_two      = 10'(stored_word(26));
        end
        decoded_due.push_back(r);
        bytes_seen = '0;
        crc_run = CRC_INIT;
    endfunction

    function automatic int tx_gap();
        int n;
        if (tx_steady) return 0;
        n = $urandom_range(0, 99);
        if (n < 55) return 0;
        if (n < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic int rx_gap();
        int n;
        if (rx_steady) return 0;
        n = $urandom_range(0, 99);
        if (n < 50) return 0;
        if (n < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 60);
    endfunction

    task automatic send_beat(logic [7:0] b, logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b, last);
        bytes_sent++;
        gap = tx_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // drop valid and let every pending packet come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (decoded_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_MAGIC:   regs_now.magic_word       = val;
            REG_VERSION: regs_now.version_byte     = val[7:0];
            REG_TYPE:    regs_now.packet_type_code = val[7:0];
            REG_FLAGS:   regs_now.allowed_flags    = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(word_t magic, logic [7:0] ver, logic [7:0] kind, word_t flags);
        write_reg(REG_MAGIC, magic);
        write_reg(REG_VERSION, {8'h00, ver});
        write_reg(REG_TYPE, {8'h00, kind});
        write_reg(REG_FLAGS, flags);
    endtask

    function automatic word_t pick_word();
        int n;
        n = $urandom_range(0, 5);
        if (n == 0) return 16'h0000;
        if (n == 1) return 16'hFFFF;
        return word_t'($urandom);
    endfunction

    function automatic void put16(int at, word_t v);
        draft[at]     = v[7:0];
        draft[at + 1] = v[15:8];
    endfunction

    function automatic void seal_crc();
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = 0; i < CRC_AT; i++) c = crc16_step(c, draft[i]);
        put16(CRC_AT, c);
    endfunction

    function automatic word_t pick_stick(bit is_signed);
        int n;
        n = $urandom_range(0, 9);
        if (n == 0) return is_signed ? word_t'(-1000) : 16'd0;
        if (n == 1) return 16'd1000;
        if (is_signed) return word_t'(int'($urandom_range(0, 2000)) - 1000);
        return word_t'($urandom_range(0, 1000));
    endfunction

    function automatic word_t bad_stick(bit is_signed);
        if (!is_signed) return word_t'($urandom_range(1001, 65535));
        if ($urandom_range(0, 1) == 0) return word_t'($urandom_range(1001, 32767));
        return word_t'(-int'($urandom_range(1001, 32768)));
    endfunction

    function automatic void fill_good_draft();
        put16(0, regs_now.magic_word);
        draft[2]  = regs_now.version_byte;
        draft[3]  = regs_now.packet_type_code;
        put16(4, word_t'($urandom));
        put16(6, word_t'($urandom));
        put16(8, word_t'($urandom) & regs_now.allowed_flags);
        draft[10] = PAYLOAD_LEN;
        draft[11] = 8'h00;
        put16(12, word_t'($urandom));
        put16(14, word_t'($urandom));
        put16(16, pick_stick(1'b0));
        put16(18, pick_stick(1'b1));
        put16(20, pick_stick(1'b1));
        put16(22, pick_stick(1'b1));
        put16(24, pick_stick(1'b0));
        put16(26, pick_stick(1'b0));
        seal_crc();
    endfunction

    function automatic void fill_draft(logic [7:0] b, bit noise);
        for (int i = 0; i < PACKET_BYTES; i++) draft[i] = noise ? 8'($urandom) : b;
    endfunction

    // break one header or payload field, then reseal unless the CRC is the target
    function automatic void break_field(status_t flaw);
        int k;
        int c;
        logic [7:0] nz;
        nz = 8'($urandom_range(1, 255));
        case (flaw)
            ST_MAGIC:    draft[$urandom_range(0, 1)] ^= nz;
            ST_VERSION:  draft[2] ^= nz;
            ST_TYPE:     draft[3] ^= nz;
            ST_LENGTH:   draft[10] ^= nz;
            ST_RESERVED: draft[11] ^= nz;
            ST_FLAGS: begin
                if (regs_now.allowed_flags != 16'hFFFF) begin
                    do k = $urandom_range(0, 15); while (regs_now.allowed_flags[k]);
                    draft[8 + k / 8] |= 8'(1 << (k % 8));
                end
            end
            ST_RANGE: begin
                c = $urandom_range(0, 5);
                put16(16 + 2 * c, bad_stick(c >= 1 && c <= 3));
            end
            default: ;
        endcase
        seal_crc();
        if (flaw == ST_CRC) draft[CRC_AT + $urandom_range(0, 1)] ^= nz;
    endfunction

    // bytes past the draft are filler, so long frames carry junk after a packet
    task automatic send_frame(int len);
        tx_steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
            send_beat(i < PACKET_BYTES ? draft[i] : 8'($urandom), i == len - 1);
        end
        frames_sent++;
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, m_tdata);
            end else begin
                want_result = decoded_due.pop_front();
                seen_result = result_t'(m_tdata[$bits(result_t)-1:0]);
                compare_field("status_code", 32'(want_result.status_code),
                              32'(seen_result.status_code));
                compare_field("sequence_res", 32'(want_result.sequence_res),
                              32'(seen_result.sequence_res));
                compare_field("session", 32'(want_result.session), 32'(seen_result.session));
                compare_field("header_flags", 32'(want_result.header_flags),
                              32'(seen_result.header_flags));
                compare_field("sender_time", want_result.sender_time, seen_result.sender_time);
                compare_field("throttle", 32'(want_result.throttle), 32'(seen_result.throttle));
                compare_field("roll", 32'(want_result.roll), 32'(seen_result.roll));
                compare_field("pitch", 32'(want_result.pitch), 32'(seen_result.pitch));
                compare_field("yaw", 32'(want_result.yaw), 32'(seen_result.yaw));
                compare_field("aux_one", 32'(want_result.aux_one), 32'(seen_result.aux_one));
                compare_field("aux_two", 32'(want_result.aux_two), 32'(seen_result.aux_two));
                compare_field("pad", 32'd0, 32'(m_tdata[TDATA_W-1:$bits(result_t)]));
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
            if (hold_rx_req) begin
                hold_rx_req = 1'b0;
                rx_holding = 1'b1;
                stall = LONG_HOLD;
            end else begin
                stall = rx_gap();
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            rx_holding = 1'b0;
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    task automatic test_reset_defaults();
        fill_good_draft();
        send_frame(PACKET_BYTES);
        fill_good_draft();
        send_frame(1);
        wait_idle();
    endtask

    task automatic test_status_order();
        set_regs(16'hA55A, 8'h03, 8'h10, 16'h00F3);
        for (int s = ST_MAGIC; s <= ST_RANGE; s++) begin
            fill_good_draft();
            break_field(status_t'(s));
            send_frame(PACKET_BYTES);
        end
        // two flaws at once: the earlier check wins
        fill_good_draft();
        break_field(ST_MAGIC);
        break_field(ST_CRC);
        send_frame(PACKET_BYTES);
        fill_good_draft();
        break_field(ST_RANGE);
        break_field(ST_FLAGS);
        send_frame(PACKET_BYTES);
        fill_good_draft();
        send_frame(PACKET_BYTES - 1);
        send_frame(PACKET_BYTES + 1);
        send_frame(MAX_FRAME);
        wait_idle();
    endtask

    task automatic test_stick_limits();
        int    spot [6];
        word_t edge_val [6];
        spot = '{16, 18, 20, 22, 24, 26};
        edge_val = '{16'd1001, 16'hFC17, 16'h8000, 16'h7FFF, 16'd1001, 16'hFFFF};
        fill_good_draft();
        for (int i = 0; i < 6; i++) put16(spot[i], 16'd1000);
        seal_crc();
        send_frame(PACKET_BYTES);
        fill_good_draft();
        for (int i = 0; i < 6; i++) put16(spot[i], (i >= 1 && i <= 3) ? 16'hFC18 : 16'd0);
        seal_crc();
        send_frame(PACKET_BYTES);
        for (int i = 0; i < 6; i++) begin
            fill_good_draft();
            put16(spot[i], edge_val[i]);
            seal_crc();
            send_frame(PACKET_BYTES);
        end
        wait_idle();
    endtask

    task automatic test_config_extremes();
        set_regs(16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
        fill_good_draft();
        put16(8, 16'hFFFF);
        seal_crc();
        send_frame(PACKET_BYTES);
        fill_draft(8'hFF, 1'b0);
        send_frame(PACKET_BYTES);
        wait_idle();
        set_regs(16'h0000, 8'h00, 8'h00, 16'h0000);
        fill_good_draft();
        put16(8, 16'h8001);
        seal_crc();
        send_frame(PACKET_BYTES);
        fill_draft(8'h00, 1'b0);
        send_frame(PACKET_BYTES);
        wait_idle();
    endtask

    task automatic test_stalled_output();
        set_regs(16'h5AA5, 8'h01, 8'h22, 16'hF0F0);
        hold_rx_req = 1'b1;
        wait (rx_holding);
        for (int i = 0; i < 8; i++) begin
            fill_good_draft();
            send_frame($urandom_range(1, 3));
        end
        for (int i = 0; i < 2; i++) begin
            fill_good_draft();
            send_frame(PACKET_BYTES);
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int      first_byte;
        int      first_frame;
        int      n;
        status_t flaw;
        first_byte  = bytes_sent;
        first_frame = frames_sent;
        while (bytes_sent - first_byte < RANDOM_BYTES ||
               frames_sent - first_frame < MIN_PACKETS) begin
            if ((frames_sent - first_frame) % 8 == 0) begin
                wait_idle();
                set_regs(pick_word(), 8'(pick_word()), 8'(pick_word()), pick_word());
            end
            n = $urandom_range(0, 99);
            if (n < 60) begin
                fill_good_draft();
                flaw = ($urandom_range(0, 1) == 0) ? ST_OK :
                       status_t'($urandom_range(ST_MAGIC, ST_RANGE));
                break_field(flaw);
                send_frame(PACKET_BYTES);
            end else if (n < 75) begin
                fill_good_draft();
                send_frame($urandom_range(1, PACKET_BYTES - 1));
            end else if (n < 85) begin
                fill_good_draft();
                send_frame($urandom_range(PACKET_BYTES + 1, MAX_FRAME));
            end else begin
                fill_draft(8'h00, 1'b1);
                send_frame($urandom_range(1, 40));
            end
        end
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < PACKET_BYTES; i++) shadow_bytes[i] = 8'h00;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_status_order();
        test_stick_limits();
        test_config_extremes();
        test_stalled_output();
        test_random_traffic();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
